>>> hdl/ring_queue_with_drop_policy_top_defines.svh
// ----------------------------------------------------------------------------
// Ring queue assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef RING_QUEUE_WITH_DROP_POLICY_TOP_DEFINES_SVH
`define RING_QUEUE_WITH_DROP_POLICY_TOP_DEFINES_SVH

// condition holds at every clock edge out of reset
`define RQDP_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds whenever the antecedent does
`define RQDP_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`endif

>>> hdl/rqdp_pkg.sv
// ----------------------------------------------------------------------------
// rqdp_pkg
// Types and constants shared by the ring queue with drop policy.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rqdp_pkg;

  localparam int DEPTH_DEF    = 256;
  localparam int MSG_BITS_DEF = 32;

  // configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 9;
  localparam logic [CFG_IDX_W-1:0] REG_QUEUE_SIZE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_POLICY = 1'b1;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic POLICY_DROP_NEW = 1'b0;
  localparam logic POLICY_DROP_OLD = 1'b1;

  typedef struct packed {
    logic        cmd;
    logic [31:0] message;
  } in_item_t;

  typedef struct packed {
    logic        accepted;
    logic        data_valid;
    logic [31:0] data;
    logic [8:0]  fill_level;
    logic        is_empty;
    logic [31:0] lost_count;
    logic [31:0] max_fill;
  } out_item_t;

endpackage

>>> hdl/rqdp_ram.sv
// ----------------------------------------------------------------------------
// rqdp_ram
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rqdp_ram #(
  parameter int WORDS  = 256,
  parameter int WIDTH  = 32,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [WORDS];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds while re is low, so a stalled result keeps its data
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hdl/ring_queue_with_drop_policy_top.sv
// ----------------------------------------------------------------------------
// Ring queue with drop policy
// Circular message queue, overflow handled by refusing or overwriting.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one command per transfer, push (message stored) or pop.
//   out_* : one result per command: accepted / popped data, fill level,
//           empty flag, saturating loss count and high-water mark.
//   cfg_* : write queue_size (index 0, empties the queue) or drop_policy
//           (index 1) while no command is outstanding.
// The result is registered and valid in the cycle after input transfer.
// Throughput is one command per cycle while no result stalls: indices and
// counters update in the accept cycle and the slot store takes a write or
// a read then, its registered read data forming part of the result register.
// When the receiver stalls a pending result, in_stall is raised and the
// result, including the read data, holds until taken.
// Reset empties the queue, clears loss count and high-water mark, sets
// queue_size to the smaller of DEPTH and 256 and selects drop-new. The
// slot store is not cleared; every slot is written before it is read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "ring_queue_with_drop_policy_top_defines.svh"

module ring_queue_with_drop_policy_top #(
  parameter int DEPTH    = rqdp_pkg::DEPTH_DEF,
  parameter int MSG_BITS = rqdp_pkg::MSG_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  rqdp_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output rqdp_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [rqdp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [rqdp_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  // queue_size is 9 bits wide, so at most 511 slots are ever addressed
  localparam int MEM_DEPTH = (DEPTH < 511) ? DEPTH : 511;
  localparam int RST_SIZE  = (DEPTH < 256) ? DEPTH : 256;
  localparam int IDX_W     = $clog2(MEM_DEPTH);

  logic [8:0]       qsize_r, qsize_nxt;
  logic             policy_r, policy_nxt;
  logic [IDX_W-1:0] wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [31:0]      gap_r, gap_nxt;
  logic [31:0]      loss_r, loss_nxt;
  logic [31:0]      hw_r, hw_nxt;

  logic             out_valid_r;
  logic             acc_r, acc_nxt;
  logic             dv_r, dv_nxt;
  logic [8:0]       fill_r, fill_nxt;
  logic             empty_r;

  logic             take;
  logic             full;
  logic             snap;
  logic [31:0]      pop_gap;
  logic [IDX_W-1:0] pop_idx;
  logic [31:0]      push_gap;
  logic             mem_we;
  logic             mem_re;
  logic [MSG_BITS-1:0] mem_rdata;
  logic [8:0]       cfg_size;

  function automatic logic [IDX_W-1:0] next_idx(input logic [IDX_W-1:0] i,
                                                 input logic [8:0] size);
    logic [9:0] n;
    n = 10'(i) + 10'd1;
    return (n >= {1'b0, size}) ? '0 : IDX_W'(n);
  endfunction

  function automatic logic [31:0] sat_inc(input logic [31:0] v);
    return (v == '1) ? v : v + 32'd1;
  endfunction

  assign in_stall = out_valid_r & out_stall;
  assign take     = in_valid & ~in_stall;

  assign full     = gap_r >= {23'd0, qsize_r};
  assign snap     = (policy_r == rqdp_pkg::POLICY_DROP_OLD) && full;
  assign pop_gap  = snap ? {23'd0, qsize_r} : gap_r;
  assign pop_idx  = snap ? wr_idx_r : rd_idx_r;
  assign push_gap = sat_inc(gap_r);

  // clamp a written size into 1..MEM_DEPTH (the smaller of DEPTH and 511)
  always_comb begin
    cfg_size = cfg_wdata;
    if (cfg_wdata == 9'd0) begin
      cfg_size = 9'd1;
    end else if ({1'b0, cfg_wdata} > 10'(MEM_DEPTH)) begin
      cfg_size = 9'(MEM_DEPTH);
    end
  end

  always_comb begin
    qsize_nxt  = qsize_r;
    policy_nxt = policy_r;
    wr_idx_nxt = wr_idx_r;
    rd_idx_nxt = rd_idx_r;
    gap_nxt    = gap_r;
    loss_nxt   = loss_r;
    hw_nxt     = hw_r;
    acc_nxt    = 1'b0;
    dv_nxt     = 1'b0;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        rqdp_pkg::REG_QUEUE_SIZE: begin
          qsize_nxt  = cfg_size;
          wr_idx_nxt = '0;
          rd_idx_nxt = '0;
          gap_nxt    = '0;
        end
        rqdp_pkg::REG_DROP_POLICY: begin
          policy_nxt = cfg_wdata[0];
        end
        default: begin
        end
      endcase
    end else if (take) begin
      if (in_data.cmd == rqdp_pkg::CMD_PUSH) begin
        if ((policy_r == rqdp_pkg::POLICY_DROP_NEW) && full) begin
          loss_nxt = sat_inc(loss_r);
        end else begin
          mem_we     = 1'b1;
          wr_idx_nxt = next_idx(wr_idx_r, qsize_r);
          gap_nxt    = push_gap;
          hw_nxt     = (push_gap > hw_r) ? push_gap : hw_r;
          acc_nxt    = 1'b1;
        end
      end else begin
        if (snap) begin
          loss_nxt = sat_inc(loss_r);
        end
        rd_idx_nxt = pop_idx;
        gap_nxt    = pop_gap;
        if (pop_gap != 32'd0) begin
          mem_re     = 1'b1;
          rd_idx_nxt = next_idx(pop_idx, qsize_r);
          gap_nxt    = pop_gap - 32'd1;
          dv_nxt     = 1'b1;
        end
      end
    end
  end

  assign fill_nxt = (gap_nxt >= {23'd0, qsize_r}) ? qsize_r : gap_nxt[8:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qsize_r     <= 9'(RST_SIZE);
      policy_r    <= rqdp_pkg::POLICY_DROP_NEW;
      wr_idx_r    <= '0;
      rd_idx_r    <= '0;
      gap_r       <= '0;
      loss_r      <= '0;
      hw_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      qsize_r    <= qsize_nxt;
      policy_r   <= policy_nxt;
      wr_idx_r   <= wr_idx_nxt;
      rd_idx_r   <= rd_idx_nxt;
      gap_r      <= gap_nxt;
      loss_r     <= loss_nxt;
      hw_r       <= hw_nxt;
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result fields, loaded with each accepted command
  always_ff @(posedge clk) begin
    if (take && !cfg_we) begin
      acc_r   <= acc_nxt;
      dv_r    <= dv_nxt;
      fill_r  <= fill_nxt;
      empty_r <= (gap_nxt == 32'd0);
    end
  end

  rqdp_ram #(
    .WORDS  (MEM_DEPTH),
    .WIDTH  (MSG_BITS),
    .ADDR_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (wr_idx_r),
    .wdata (MSG_BITS'(in_data.message)),
    .re    (mem_re),
    .raddr (pop_idx),
    .rdata (mem_rdata)
  );

  assign out_valid           = out_valid_r;
  assign out_data.accepted   = acc_r;
  assign out_data.data_valid = dv_r;
  assign out_data.data       = dv_r ? 32'(mem_rdata) : 32'd0;
  assign out_data.fill_level = fill_r;
  assign out_data.is_empty   = empty_r;
  assign out_data.lost_count = loss_r;
  assign out_data.max_fill   = hw_r;

  // ---- assertions ----
  `RQDP_ASSERT_ALWAYS(a_idx_in_range, ({1'b0, rd_idx_r} < 10'(qsize_r)) && ({1'b0, wr_idx_r} < 10'(qsize_r)), "queue index outside used size")
  `RQDP_ASSERT_IMPL(a_push_or_pop, out_valid_r, !(acc_r && dv_r), "result both accepted and popped")
  `RQDP_ASSERT_IMPL(a_empty_fill, out_valid_r, empty_r == (fill_r == 9'd0), "empty flag disagrees with fill level")
  `RQDP_ASSERT_IMPL(a_loss_monotonic, $past(rst_n), loss_r >= $past(loss_r), "loss count decreased")

endmodule
